// ===== design/assert_macros.svh =====
// Assertion macros used by the top design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_HOLDS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("check failed");
`define CHK_NEXT(label, clk, rst, cond, nxt) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) \
      else $error("check failed");
`else
`define CHK_HOLDS(label, clk, rst, prop)
`define CHK_NEXT(label, clk, rst, cond, nxt)
`endif
`endif

// ===== design/rbd_pkg.sv =====
// Types, constants, sampling table and helpers of the rotated brief descriptor.
package rbd_pkg;
   localparam int PATCH = 31;
   localparam int DESC_BITS = 256;
   localparam int CENTRE = 15;
   localparam int CW = 58;
   localparam int ZW = 25;
   localparam int AW = 13;
   localparam int STEPS = 21;
   localparam int WORDS = 10;
   localparam logic [11:0] FRAME_END = 12'd4095;
   localparam logic signed [ZW-1:0] HALF_PI_Q20 = 25'sd1647099;
   localparam logic signed [ZW-1:0] PI_Q20 = 25'sd3294199;
   localparam logic signed [CW-1:0] GAIN_Q30 = 58'sd652032874;

   typedef logic [PATCH-1:0][7:0] column_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_PREP, ST_VEC_RUN, ST_ROT_GO, ST_ROT_RUN, ST_SAMPLE, ST_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic vectoring;
   } cordic_ctl_type;

   typedef struct packed {
      logic signed [4:0] x0;
      logic signed [4:0] y0;
      logic signed [4:0] x1;
      logic signed [4:0] y1;
   } pair_type;

   typedef struct packed {
      logic [4:0] row;
      logic [4:0] col;
   } point_type;

   localparam pair_type PAIR_TABLE [DESC_BITS] = '{
'{8,-3,9,5},'{4,2,7,-12},'{-11,9,-8,2},'{7,-12,12,-13},'{2,-13,2,12},'{1,-7,1,6},
'{-2,-10,-2,-4},'{-13,-13,-11,-8},'{-13,-3,-12,-9},'{10,4,11,9},'{-13,-8,-8,-9},
'{-11,7,-9,12},'{7,7,12,6},'{-4,-5,-3,0},'{-13,2,-12,-3},'{-9,0,-7,5},'{12,-6,12,-1},
'{-3,6,-2,12},'{-6,-13,-4,-8},'{11,-13,12,-8},'{4,7,5,1},'{5,-3,10,-3},'{3,-7,6,12},
'{-8,-7,-6,-2},'{-2,11,-1,-10},'{-13,12,-8,10},'{-7,3,-5,-3},'{-4,2,-3,7},
'{-10,-12,-6,11},'{5,-12,6,-7},'{5,-6,7,-1},'{1,0,4,-5},'{9,11,11,-13},'{4,7,4,12},
'{2,-1,4,4},'{-4,-12,-2,7},'{-8,-5,-7,-10},'{4,11,9,12},'{0,-8,1,-13},'{-13,-2,-8,2},
'{-3,-2,-2,3},'{-6,9,-4,-9},'{8,12,10,7},'{0,9,1,3},'{7,-5,11,-10},'{-13,-6,-11,0},
'{10,7,12,1},'{-6,-3,-6,12},'{10,-9,12,-4},'{-13,8,-8,-12},'{-13,0,-8,-4},'{3,3,7,8},
'{5,7,10,-7},'{-1,7,1,-12},'{3,-10,5,6},'{2,-4,3,-10},'{-13,0,-13,5},'{-13,-7,-12,12},
'{-13,3,-11,8},'{-7,12,-4,7},'{6,-10,12,8},'{-9,-1,-7,-6},'{-2,-5,0,12},'{-12,5,-7,5},
'{3,-10,8,-13},'{-7,-7,-4,5},'{-3,-2,-1,-7},'{2,9,5,-11},'{-11,-13,-5,-13},'{-1,6,0,-1},
'{5,-3,5,2},'{-4,-13,-4,12},'{-9,-6,-9,6},'{-12,-10,-8,-4},'{10,2,12,-3},'{7,12,12,12},
'{-7,-13,-6,5},'{-4,9,-3,4},'{7,-1,12,2},'{-7,6,-5,1},'{-13,11,-12,5},'{-3,7,-2,-6},
'{7,-8,12,-7},'{-13,-7,-11,-12},'{1,-3,12,12},'{2,-6,3,0},'{-4,3,-2,-13},'{-1,-13,1,9},
'{7,1,8,-6},'{1,-1,3,12},'{9,1,12,6},'{-1,-9,-1,3},'{-13,-13,-10,5},'{7,7,10,12},
'{12,-5,12,9},'{6,3,7,11},'{5,-13,6,10},'{2,-12,2,3},'{3,8,4,-6},'{2,6,12,-13},
'{9,-12,10,3},'{-8,4,-7,9},'{-11,12,-4,-6},'{1,12,2,-8},'{6,-9,7,-4},'{2,3,3,-2},
'{6,3,11,0},'{3,-3,8,-8},'{7,8,9,3},'{-11,-5,-6,-4},'{-10,11,-5,10},'{-5,-8,-3,12},
'{-10,5,-9,0},'{8,-1,12,-6},'{4,-6,6,-11},'{-10,12,-8,7},'{4,-2,6,7},'{-2,0,-2,12},
'{-5,-8,-5,2},'{7,-6,10,12},'{-9,-13,-8,-8},'{-5,-13,-5,-2},'{8,-8,9,-13},
'{-9,-11,-9,0},'{1,-8,1,-2},'{7,-4,9,1},'{-2,1,-1,-4},'{11,-6,12,-11},'{-12,-9,-6,4},
'{3,7,7,12},'{5,5,10,8},'{0,-4,2,8},'{-9,12,-5,-13},'{0,7,2,12},'{-1,2,1,7},
'{5,11,7,-9},'{3,5,6,-8},'{-13,-4,-8,9},'{-5,9,-3,-3},'{-4,-7,-3,-12},'{6,5,8,0},
'{-7,6,-6,12},'{-13,6,-5,-2},'{1,-10,3,10},'{4,1,8,-4},'{-2,-2,2,-13},'{2,-12,12,12},
'{-2,-13,0,-6},'{4,1,9,3},'{-6,-10,-3,-5},'{-3,-13,-1,1},'{7,5,12,-11},'{4,-2,5,-7},
'{-13,9,-9,-5},'{7,1,8,6},'{7,-8,7,6},'{-7,-4,-7,1},'{-8,11,-7,-8},'{-13,6,-12,-8},
'{2,4,3,9},'{10,-5,12,3},'{-6,-5,-6,7},'{8,-3,9,-8},'{2,-12,2,8},'{-11,-2,-10,3},
'{-12,-13,-7,-9},'{-11,0,-10,-5},'{5,-3,11,8},'{-2,-13,-1,12},'{-1,-8,0,9},
'{-13,-11,-12,-5},'{-10,-2,-10,11},'{-3,9,-2,-13},'{2,-3,3,2},'{-9,-13,-4,0},
'{-4,6,-3,-10},'{-4,12,-2,-7},'{-6,-11,-4,9},'{6,-3,6,11},'{-13,11,-5,5},'{11,11,12,6},
'{7,-5,12,-2},'{-1,12,0,7},'{-4,-8,-3,-2},'{-7,1,-6,7},'{-13,-12,-8,-13},'{-7,-2,-6,-8},
'{-8,5,-6,-9},'{-5,-1,-4,5},'{-13,7,-8,10},'{1,5,5,-13},'{1,0,10,-13},'{9,12,10,-1},
'{5,-8,10,-9},'{-1,11,1,-13},'{-9,-3,-6,2},'{-1,-10,1,12},'{-13,1,-8,-10},
'{8,-11,10,-6},'{2,-13,3,-6},'{7,-13,12,-9},'{-10,-10,-5,-7},'{-10,-8,-8,-13},
'{4,-6,8,5},'{3,12,8,-13},'{-4,2,-3,-3},'{5,-13,10,-12},'{4,-13,5,-1},'{-9,9,-4,3},
'{0,3,3,-9},'{-12,1,-6,1},'{3,2,4,-8},'{-10,-10,-10,9},'{8,-13,12,12},'{-8,-12,-6,-5},
'{2,2,3,7},'{10,6,11,-8},'{6,8,8,-12},'{-7,10,-6,5},'{-3,-9,-3,9},'{-1,-13,-1,5},
'{-3,-7,-3,4},'{-8,-2,-8,3},'{4,2,12,12},'{2,-5,3,11},'{6,-9,11,-13},'{3,-1,7,12},
'{11,-1,12,4},'{-3,0,-3,6},'{4,-11,4,12},'{2,-4,2,1},'{-10,-6,-8,1},'{-13,7,-11,1},
'{-13,12,-11,-13},'{6,0,11,-13},'{0,-1,1,4},'{-13,3,-9,-2},'{-9,8,-6,-3},
'{-13,-6,-8,-2},'{5,-9,8,10},'{2,7,3,-9},'{-1,-6,-1,-1},'{9,5,11,-2},'{11,-3,12,-8},
'{3,0,3,5},'{-1,4,0,10},'{3,-6,4,5},'{-13,0,-10,5},'{5,8,12,11},'{8,9,9,-6},
'{7,-4,8,-12},'{-10,4,-10,9},'{7,3,12,4},'{9,-7,10,-2},'{7,0,12,-2},'{-1,-6,0,-11}
   };

   function automatic logic signed [ZW-1:0] atan_q20(input logic [4:0] i);
      logic signed [ZW-1:0] v;
      unique case (i)
         5'd0: v = 25'sd823550;
         5'd1: v = 25'sd486170;
         5'd2: v = 25'sd256879;
         5'd3: v = 25'sd130396;
         5'd4: v = 25'sd65451;
         5'd5: v = 25'sd32757;
         5'd6: v = 25'sd16383;
         5'd7: v = 25'sd8192;
         5'd8: v = 25'sd4096;
         5'd9: v = 25'sd2048;
         5'd10: v = 25'sd1024;
         5'd11: v = 25'sd512;
         5'd12: v = 25'sd256;
         5'd13: v = 25'sd128;
         5'd14: v = 25'sd64;
         5'd15: v = 25'sd32;
         5'd16: v = 25'sd16;
         5'd17: v = 25'sd8;
         5'd18: v = 25'sd4;
         5'd19: v = 25'sd2;
         5'd20: v = 25'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

   // product / 2048 rounded toward zero
   function automatic logic signed [7:0] trunc_q11(input logic signed [17:0] p);
      logic signed [17:0] t;
      t = (p < 0) ? ((p + 18'sd2047) >>> 11) : (p >>> 11);
      return t[7:0];
   endfunction

   function automatic point_type rotate_point(input logic signed [4:0] px,
                                              input logic signed [4:0] py,
                                              input logic signed [AW-1:0] a,
                                              input logic signed [AW-1:0] b);
      logic signed [17:0] pxb, pya, pxa, pyb;
      logic signed [7:0] r, q;
      point_type pt;
      pxb = px * b;
      pya = py * a;
      pxa = px * a;
      pyb = py * b;
      r = trunc_q11(pxb) + trunc_q11(pya) + 8'sd15;
      q = trunc_q11(pxa) - trunc_q11(pyb) + 8'sd15;
      pt.row = r[4:0];
      pt.col = q[4:0];
      return pt;
   endfunction
endpackage

// ===== design/rbd_channels.sv =====
// Request and response channel interfaces.
interface rbd_req_if;
   logic valid;
   logic ready;
   logic [63:0] pixels_rows_0_to_7;
   logic [63:0] pixels_rows_8_to_15;
   logic [63:0] pixels_rows_16_to_23;
   logic [55:0] pixels_rows_24_to_30;
   logic signed [23:0] moment_horizontal;
   logic signed [23:0] moment_vertical;
   logic [11:0] keypoint_x;
   logic [11:0] keypoint_y;
   logic keypoint_valid;
   modport source (output valid, pixels_rows_0_to_7, pixels_rows_8_to_15,
      pixels_rows_16_to_23, pixels_rows_24_to_30, moment_horizontal,
      moment_vertical, keypoint_x, keypoint_y, keypoint_valid, input ready);
   modport sink (input valid, pixels_rows_0_to_7, pixels_rows_8_to_15,
      pixels_rows_16_to_23, pixels_rows_24_to_30, moment_horizontal,
      moment_vertical, keypoint_x, keypoint_y, keypoint_valid, output ready);
endinterface

interface rbd_rsp_if;
   logic valid;
   logic ready;
   logic [31:0] descriptor_word;
   logic last_of_descriptor;
   logic end_of_stream;
   modport source (output valid, descriptor_word, last_of_descriptor, end_of_stream,
      input ready);
   modport sink (input valid, descriptor_word, last_of_descriptor, end_of_stream,
      output ready);
endinterface

// ===== design/rbd_cordic.sv =====
// Shared CORDIC unit, one iteration per cycle, vectoring or rotation mode.
module rbd_cordic (
   input  logic clock,
   input  logic reset,
   input  rbd_pkg::cordic_ctl_type ctl,
   input  logic signed [rbd_pkg::CW-1:0] x_start,
   input  logic signed [rbd_pkg::CW-1:0] y_start,
   input  logic signed [rbd_pkg::ZW-1:0] z_start,
   output logic signed [rbd_pkg::CW-1:0] x_res,
   output logic signed [rbd_pkg::CW-1:0] y_res,
   output logic signed [rbd_pkg::ZW-1:0] z_res,
   output logic done
);
   import rbd_pkg::*;

   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ZW-1:0] z_ff, z_in;
   logic [4:0] step_ff, step_in;
   logic busy_ff, busy_in, done_ff, done_in, vec_ff, vec_in;
   logic signed [CW-1:0] dx, dy;
   logic signed [ZW-1:0] da;
   logic plus;

   always_comb begin
      dx = y_ff >>> step_ff;
      dy = x_ff >>> step_ff;
      da = atan_q20(step_ff);
      // vectoring drives y to zero, rotation drives z to zero
      plus = vec_ff ? (y_ff < 0) : (z_ff >= 0);
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      vec_in = vec_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         x_in = x_start;
         y_in = y_start;
         z_in = z_start;
         step_in = '0;
         busy_in = 1'b1;
         vec_in = ctl.vectoring;
      end else if (busy_ff) begin
         if (plus) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - da;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + da;
         end
         step_in = step_ff + 5'd1;
         if (step_ff == 5'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      step_ff <= step_in;
      vec_ff <= vec_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign x_res = x_ff;
   assign y_res = y_ff;
   assign z_res = z_ff;
   assign done = done_ff;
endmodule

// ===== design/rbd_window.sv =====
// Circular column store of the 31x31 pixel window, two registered read ports.
module rbd_window (
   input  logic clock,
   input  logic reset,
   input  logic wr_en,
   input  rbd_pkg::column_type wr_col,
   input  logic [4:0] rd_addr_a,
   input  logic [4:0] rd_addr_b,
   output rbd_pkg::column_type rd_col_a,
   output rbd_pkg::column_type rd_col_b,
   output logic rd_ok_a,
   output logic rd_ok_b,
   output logic [4:0] base
);
   import rbd_pkg::*;

   column_type mem [PATCH];
   logic [PATCH-1:0] filled_ff;
   logic [4:0] wp_ff;
   column_type rd_a_ff, rd_b_ff;
   logic ok_a_ff, ok_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wp_ff] <= wr_col;
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
      ok_a_ff <= filled_ff[rd_addr_a];
      ok_b_ff <= filled_ff[rd_addr_b];
   end

   // wp points at the oldest column, which is the next one overwritten
   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff <= '0;
         wp_ff <= '0;
      end else if (wr_en) begin
         filled_ff[wp_ff] <= 1'b1;
         wp_ff <= (wp_ff == 5'(PATCH - 1)) ? 5'd0 : wp_ff + 5'd1;
      end
   end

   assign rd_col_a = rd_a_ff;
   assign rd_col_b = rd_b_ff;
   assign rd_ok_a = ok_a_ff;
   assign rd_ok_b = ok_b_ff;
   assign base = wp_ff;
endmodule

// ===== design/rotated_brief_descriptor_top.sv =====
// A keypoint word runs a vectoring pass and then a rotation pass on the shared CORDIC unit
// (21 iterations each), then the 256 pair lookups, one pair per cycle, and then ten output
// words at one per cycle when the sink is ready.
// Zero moments skip the vectoring pass.
// A column without the keypoint flag keeps the sequencer idle and is taken back to back.
// Synchronous reset clears the sequencer and marks every window column as zero.
module rotated_brief_descriptor_top (
   input  logic clock,
   input  logic reset,
   rbd_req_if.sink req,
   rbd_rsp_if.source rsp
);
   import rbd_pkg::*;
   `include "assert_macros.svh"

   state_type state_ff, state_in;
   logic signed [23:0] m10_ff, m01_ff;
   logic [11:0] kx_ff, ky_ff;
   logic signed [14:0] angle_ff, angle_in;
   logic neg_ff, neg_in;
   logic signed [AW-1:0] a_ff, a_in, b_ff, b_in;
   logic [8:0] cnt_ff, cnt_in;
   logic s1_valid_ff;
   logic [4:0] row0_ff, row1_ff;
   logic zero0_ff, zero1_ff;
   logic [DESC_BITS-1:0] desc_ff;
   logic [3:0] idx_ff, idx_in;

   logic accept, issue;
   cordic_ctl_type cctl;
   logic signed [CW-1:0] cx0, cy0, cx, cy, sx, sy, xf, yf, rx, ry;
   logic signed [ZW-1:0] cz0, cz, z2;
   logic signed [ZW:0] zr;
   logic cdone;
   column_type col_in, col_a, col_b;
   logic ok_a, ok_b;
   logic [4:0] base, phys0, phys1;
   logic [5:0] sum0, sum1;
   pair_type pr;
   point_type p0, p1;
   logic [7:0] pix0, pix1;

   assign accept = req.valid && req.ready;
   assign req.ready = (state_ff == ST_IDLE);
   assign col_in = {req.pixels_rows_24_to_30, req.pixels_rows_16_to_23,
                    req.pixels_rows_8_to_15, req.pixels_rows_0_to_7};

   rbd_window u_window (
      .clock(clock), .reset(reset), .wr_en(accept), .wr_col(col_in),
      .rd_addr_a(phys0), .rd_addr_b(phys1), .rd_col_a(col_a), .rd_col_b(col_b),
      .rd_ok_a(ok_a), .rd_ok_b(ok_b), .base(base)
   );

   rbd_cordic u_cordic (
      .clock(clock), .reset(reset), .ctl(cctl), .x_start(cx0), .y_start(cy0),
      .z_start(cz0), .x_res(cx), .y_res(cy), .z_res(cz), .done(cdone)
   );

   // operand setup for the shared unit
   always_comb begin
      sx = CW'(m10_ff) <<< 30;
      sy = CW'(m01_ff) <<< 30;
      z2 = ZW'(angle_ff) <<< 9;
      neg_in = neg_ff;
      cctl = '0;
      cx0 = sx;
      cy0 = sy;
      cz0 = '0;
      if (state_ff == ST_PREP) begin
         cctl.start = !(m10_ff == 24'sd0 && m01_ff == 24'sd0);
         cctl.vectoring = 1'b1;
         if (sx < 0) begin
            if (sy >= 0) begin
               cx0 = sy;
               cy0 = -sx;
               cz0 = HALF_PI_Q20;
            end else begin
               cx0 = -sy;
               cy0 = sx;
               cz0 = -HALF_PI_Q20;
            end
         end
      end else if (state_ff == ST_ROT_GO) begin
         cctl.start = 1'b1;
         cx0 = GAIN_Q30;
         cy0 = '0;
         neg_in = 1'b0;
         if (z2 > HALF_PI_Q20) begin
            cz0 = z2 - PI_Q20;
            neg_in = 1'b1;
         end else if (z2 < -HALF_PI_Q20) begin
            cz0 = z2 + PI_Q20;
            neg_in = 1'b1;
         end else begin
            cz0 = z2;
         end
      end
   end

   // rounding of unit results
   always_comb begin
      zr = (ZW+1)'(cz) + 26'sd256;
      angle_in = 15'(zr >>> 9);
      xf = neg_ff ? -cx : cx;
      yf = neg_ff ? -cy : cy;
      rx = (xf + 58'sd262144) >>> 19;
      ry = (yf + 58'sd262144) >>> 19;
      a_in = rx[AW-1:0];
      b_in = ry[AW-1:0];
   end

   // pair addressing
   always_comb begin
      pr = PAIR_TABLE[cnt_ff[7:0]];
      p0 = rotate_point(pr.x0, pr.y0, a_ff, b_ff);
      p1 = rotate_point(pr.x1, pr.y1, a_ff, b_ff);
      sum0 = {1'b0, base} + {1'b0, p0.col};
      sum1 = {1'b0, base} + {1'b0, p1.col};
      phys0 = (sum0 >= 6'(PATCH)) ? 5'(sum0 - 6'(PATCH)) : sum0[4:0];
      phys1 = (sum1 >= 6'(PATCH)) ? 5'(sum1 - 6'(PATCH)) : sum1[4:0];
      issue = (state_ff == ST_SAMPLE) && !cnt_ff[8];
      pix0 = (zero0_ff || !ok_a) ? 8'd0 : col_a[row0_ff];
      pix1 = (zero1_ff || !ok_b) ? 8'd0 : col_b[row1_ff];
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      unique case (state_ff)
         ST_IDLE: if (accept && req.keypoint_valid) state_in = ST_PREP;
         ST_PREP: state_in = cctl.start ? ST_VEC_RUN : ST_ROT_GO;
         ST_VEC_RUN: if (cdone) state_in = ST_ROT_GO;
         ST_ROT_GO: state_in = ST_ROT_RUN;
         ST_ROT_RUN: if (cdone) begin
            state_in = ST_SAMPLE;
            cnt_in = '0;
         end
         ST_SAMPLE: begin
            if (issue) cnt_in = cnt_ff + 9'd1;
            if (cnt_ff[8] && !s1_valid_ff) begin
               state_in = ST_OUT;
               idx_in = '0;
            end
         end
         ST_OUT: if (rsp.ready) begin
            idx_in = idx_ff + 4'd1;
            if (idx_ff == 4'(WORDS - 1)) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         s1_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         s1_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      idx_ff <= idx_in;
      neg_ff <= neg_in;
      row0_ff <= p0.row;
      row1_ff <= p1.row;
      zero0_ff <= (p0.row == 5'd31) || (p0.col == 5'd31);
      zero1_ff <= (p1.row == 5'd31) || (p1.col == 5'd31);
      if (accept) begin
         m10_ff <= req.moment_horizontal;
         m01_ff <= req.moment_vertical;
         kx_ff <= req.keypoint_x;
         ky_ff <= req.keypoint_y;
      end
      if (state_ff == ST_PREP && !cctl.start) angle_ff <= '0;
      if (state_ff == ST_VEC_RUN && cdone) angle_ff <= angle_in;
      if (state_ff == ST_ROT_RUN && cdone) begin
         a_ff <= a_in;
         b_ff <= b_in;
      end
      if (s1_valid_ff) desc_ff <= {pix0 < pix1, desc_ff[DESC_BITS-1:1]};
      else if (state_ff == ST_OUT && rsp.ready && idx_ff < 4'd8)
         desc_ff <= desc_ff >> 32;
   end

   assign rsp.valid = (state_ff == ST_OUT);
   assign rsp.descriptor_word = (idx_ff < 4'd8) ? desc_ff[31:0] :
                                (idx_ff == 4'd8) ? {20'd0, kx_ff} : {20'd0, ky_ff};
   assign rsp.last_of_descriptor = (idx_ff == 4'(WORDS - 1));
   assign rsp.end_of_stream = (idx_ff == 4'(WORDS - 1)) && (kx_ff == FRAME_END) &&
                              (ky_ff == FRAME_END);

   `CHK_HOLDS(chk_no_overlap, clock, reset, !(req.ready && rsp.valid))
   `CHK_HOLDS(chk_lookup_in_sample, clock, reset, !s1_valid_ff || (state_ff == ST_SAMPLE))
   `CHK_HOLDS(chk_word_index, clock, reset, !rsp.valid || (idx_ff < 4'(WORDS)))
   `CHK_NEXT(chk_out_after_sample, clock, reset,
      (state_ff == ST_SAMPLE) && cnt_ff[8] && !s1_valid_ff, rsp.valid)
endmodule
